// File: sv/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg: running mean / variance constants
// Fixed field widths and divider sizing for the running mean and variance core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned MeanAccW = 32;   // 16.16 running mean
  localparam int unsigned SqSumW   = 64;   // sum of squared deviations, 16 frac bits
  localparam int unsigned MeanW    = 24;   // 16.8 output mean
  localparam int unsigned VarW     = 48;   // 40.8 output variance
  localparam int unsigned FracW    = 16;
  localparam int unsigned VarShift = 8;

  // shared divider: quotient bits resolved per cycle and sweep lengths
  localparam int unsigned DivSteps      = 2;
  localparam int unsigned DivDvdW       = SqSumW;
  localparam int unsigned DivCntW       = 5;
  localparam int unsigned MeanDivCycles = MeanAccW / DivSteps;
  localparam int unsigned VarDivCycles  = SqSumW / DivSteps;

endpackage

`default_nettype wire

// File: sv/running_mean_variance_core.sv
// ----------------------------------------------------------------------------
// running_mean_variance_core: Welford running mean and variance
// Folds 16-bit samples into a saturating-count running mean and sum of squares.
// ----------------------------------------------------------------------------
// One input beat produces one output beat. A clear beat or the first sample
// after reset or clear goes straight from idle to the emit state. Any other
// sample passes through the mean division, the mean update, the product, the
// accumulate, the variance division and the emit state in turn. Both divisions
// use the single shared restoring divider, which resolves two quotient bits per
// cycle and serves the mean and the variance division in turn.
// No new beat is taken while a sample is in work; the result is held in an
// output register until the receiver takes it. The count saturates at WINDOW,
// after which the mean behaves as an exponential average with weight 1/WINDOW.
`default_nettype none

module running_mean_variance_core #(
  parameter int unsigned WINDOW = 256,
  localparam int unsigned CntW  = $clog2(WINDOW + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rmv_pkg::SampleW-1:0]   sample_i,
  input  wire logic                          clear_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [rmv_pkg::MeanW-1:0]          mean_value_o,
  output logic [rmv_pkg::VarW-1:0]           variance_value_o,
  output logic [CntW-1:0]                    sample_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_UPDATE,
    ST_MUL,
    ST_ACC,
    ST_DIV_VAR,
    ST_EMIT
  } state_e;

  localparam int unsigned AccW  = rmv_pkg::MeanAccW;
  localparam int unsigned SqW   = rmv_pkg::SqSumW;
  localparam int unsigned DvdW  = rmv_pkg::DivDvdW;
  localparam int unsigned PrdW  = 2 * AccW;

  state_e                         state_q;
  logic                           out_valid_q;
  logic [CntW-1:0]                count_q;
  logic [AccW-1:0]                mean_q;
  logic [SqW-1:0]                 sq_sum_q;
  logic [rmv_pkg::SampleW-1:0]    sample_q;
  logic                           up_q;
  logic [AccW-1:0]                d1_q;
  logic [AccW-1:0]                d2_q;
  logic [PrdW-1:0]                prod_q;

  // shared divider
  logic [DvdW-1:0]                div_dvd_q;
  logic [DvdW-1:0]                div_dvd_d;
  logic [CntW-1:0]                div_rem_q;
  logic [CntW-1:0]                div_rem_d;
  logic [CntW-1:0]                div_dsr_q;
  logic [rmv_pkg::DivCntW-1:0]    div_cnt_q;

  logic [rmv_pkg::MeanW-1:0]      mean_out_q;
  logic [rmv_pkg::VarW-1:0]       var_out_q;
  logic [CntW-1:0]                count_out_q;

  // combinational helpers
  logic [CntW-1:0]                count_next;
  logic [AccW-1:0]                sample_fix;
  logic                           in_up;
  logic [AccW-1:0]                in_d1;
  logic [AccW-1:0]                quot_mean;
  logic [AccW-1:0]                new_mean;
  logic [AccW-1:0]                sample_held;
  logic [AccW-1:0]                new_d2;
  logic [SqW:0]                   sq_sum_ext;
  logic [SqW-1:0]                 sq_sum_sat;
  logic [rmv_pkg::VarW-1:0]       var_value;

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign mean_value_o     = mean_out_q;
  assign variance_value_o = var_out_q;
  assign sample_count_o   = count_out_q;

  // two restoring quotient bits per cycle
  always_comb begin
    logic [CntW:0]   trial;
    logic [CntW-1:0] rem;
    logic [DvdW-1:0] dvd;
    rem = div_rem_q;
    dvd = div_dvd_q;
    for (int i = 0; i < int'(rmv_pkg::DivSteps); i++) begin
      trial = {rem, dvd[DvdW-1]};
      dvd   = {dvd[DvdW-2:0], 1'b0};
      if (trial >= {1'b0, div_dsr_q}) begin
        trial  = trial - {1'b0, div_dsr_q};
        dvd[0] = 1'b1;
      end
      rem = trial[CntW-1:0];
    end
    div_rem_d = rem;
    div_dvd_d = dvd;
  end

  always_comb begin
    count_next  = (count_q < CntW'(WINDOW)) ? count_q + CntW'(1) : count_q;
    sample_fix  = {sample_i, {rmv_pkg::FracW{1'b0}}};
    in_up       = (sample_fix >= mean_q);
    in_d1       = in_up ? (sample_fix - mean_q) : (mean_q - sample_fix);

    quot_mean   = div_dvd_q[AccW-1:0];
    new_mean    = up_q ? (mean_q + quot_mean) : (mean_q - quot_mean);
    sample_held = {sample_q, {rmv_pkg::FracW{1'b0}}};
    new_d2      = (sample_held >= new_mean) ? (sample_held - new_mean)
                                            : (new_mean - sample_held);

    sq_sum_ext  = {1'b0, sq_sum_q}
                + {{(SqW + 1 - (PrdW - rmv_pkg::FracW)){1'b0}},
                   prod_q[PrdW-1:rmv_pkg::FracW]};
    sq_sum_sat  = sq_sum_ext[SqW] ? {SqW{1'b1}} : sq_sum_ext[SqW-1:0];

    // quotient >> 8, saturating at the 48-bit field maximum
    if (div_dvd_q[DvdW-1:rmv_pkg::VarW + rmv_pkg::VarShift] != '0) begin
      var_value = {rmv_pkg::VarW{1'b1}};
    end else begin
      var_value = div_dvd_q[rmv_pkg::VarW + rmv_pkg::VarShift - 1:rmv_pkg::VarShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      mean_q      <= '0;
      sq_sum_q    <= '0;
    end else begin
      // in ST_EMIT the reload below owns the valid flag
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            div_rem_q <= '0;
            if (clear_i) begin
              count_q   <= '0;
              mean_q    <= '0;
              sq_sum_q  <= '0;
              div_dvd_q <= '0;
              state_q   <= ST_EMIT;
            end else if (count_next <= CntW'(1)) begin
              // first sample: mean takes the sample, no spread yet
              count_q   <= count_next;
              mean_q    <= sample_fix;
              sq_sum_q  <= '0;
              div_dvd_q <= '0;
              state_q   <= ST_EMIT;
            end else begin
              count_q   <= count_next;
              sample_q  <= sample_i;
              up_q      <= in_up;
              d1_q      <= in_d1;
              div_dvd_q <= {in_d1, {(DvdW - AccW){1'b0}}};
              div_dsr_q <= count_next;
              div_cnt_q <= rmv_pkg::DivCntW'(rmv_pkg::MeanDivCycles - 1);
              state_q   <= ST_DIV_MEAN;
            end
          end
        end
        ST_DIV_MEAN: begin
          div_dvd_q <= div_dvd_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q - rmv_pkg::DivCntW'(1);
          if (div_cnt_q == '0) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          mean_q  <= new_mean;
          d2_q    <= new_d2;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= d1_q * d2_q;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          // count is at least two here, so the divisor is never zero
          sq_sum_q  <= sq_sum_sat;
          div_dvd_q <= sq_sum_sat;
          div_rem_q <= '0;
          div_dsr_q <= count_q - CntW'(1);
          div_cnt_q <= rmv_pkg::DivCntW'(rmv_pkg::VarDivCycles - 1);
          state_q   <= ST_DIV_VAR;
        end
        ST_DIV_VAR: begin
          div_dvd_q <= div_dvd_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q - rmv_pkg::DivCntW'(1);
          if (div_cnt_q == '0) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // wait until the previous beat has left the output register
          if (!out_valid_q || !out_stall_i) begin
            mean_out_q  <= mean_q[AccW-1:AccW-rmv_pkg::MeanW];
            var_out_q   <= var_value;
            count_out_q <= count_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: running mean / variance core testbench
// Drives samples and clears through the valid/stall input channel. Each beat
// is scored against an in-bench Welford predictor, and each output beat is
// checked field by field in order of arrival. Random gaps, quiet stretches and
// long receiver hold-offs put pressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned WINDOW       = 256;
  localparam int unsigned CNT_W        = $clog2(WINDOW + 1);
  localparam int unsigned RAND_ITEMS   = 850;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned WATCHDOG_MAX = 4000;
  localparam int unsigned TAIL_CYCLES  = 120;
  localparam logic [63:0] SQ_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAR_MAX      = 64'h0000_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_RANDOM,
    MODE_EXTREME,
    MODE_CLUSTER,
    MODE_STEADY
  } sample_mode_e;

  typedef struct {
    logic [rmv_pkg::SampleW-1:0] sample;
    logic                        clear;
    logic                        drain;  // wait until every result is back before offering
  } sample_beat_t;

  typedef struct {
    logic [rmv_pkg::MeanW-1:0] mean;
    logic [rmv_pkg::VarW-1:0]  variance;
    logic [CNT_W-1:0]          count;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [rmv_pkg::SampleW-1:0] sample_i = '0;
  logic                        clear_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [rmv_pkg::MeanW-1:0]   mean_value_o;
  logic [rmv_pkg::VarW-1:0]    variance_value_o;
  logic [CNT_W-1:0]            sample_count_o;

  running_mean_variance_core #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .clear_i         (clear_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mean_value_o    (mean_value_o),
    .variance_value_o(variance_value_o),
    .sample_count_o  (sample_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sample_beat_t pending_q[$];
  stats_t       stats_q[$];

  // predictor state
  logic [CNT_W-1:0] fold_count;
  logic [31:0]      fold_mean;
  logic [63:0]      fold_sqsum;

  int unsigned n_sent;
  int unsigned n_clears;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_saturated;
  int unsigned n_holds;
  int unsigned hold_at = 150;
  logic [63:0] peak_sqsum;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 24);
    return $urandom_range(40, 120);
  endfunction

  function automatic stats_t welford_fold(logic [rmv_pkg::SampleW-1:0] smp, logic clr);
    logic [63:0] s, prev_mean, d1, q, new_mean, d2, inc, vq;
    logic        up;
    stats_t      r;
    if (clr) begin
      fold_count = '0;
      fold_mean  = '0;
      fold_sqsum = '0;
    end else begin
      if (fold_count < WINDOW) fold_count = fold_count + 1'b1;
      s = {32'h0, smp, 16'h0};
      if (fold_count <= 1) begin
        fold_mean  = s[31:0];
        fold_sqsum = '0;
      end else begin
        prev_mean = {32'h0, fold_mean};
        up        = (s >= prev_mean);
        d1        = up ? (s - prev_mean) : (prev_mean - s);
        q         = d1 / 64'(fold_count);
        new_mean  = up ? (prev_mean + q) : (prev_mean - q);
        d2        = (s >= new_mean) ? (s - new_mean) : (new_mean - s);
        // both differences stay below 2^32, so the product fits in 64 bits
        inc       = (d1 * d2) >> rmv_pkg::FracW;
        fold_mean = new_mean[31:0];
        if (fold_sqsum > SQ_MAX - inc) fold_sqsum = SQ_MAX;
        else fold_sqsum = fold_sqsum + inc;
      end
      if (fold_count == WINDOW) n_saturated++;
      if (fold_sqsum > peak_sqsum) peak_sqsum = fold_sqsum;
    end
    vq = '0;
    if (fold_count > 1) begin
      vq = (fold_sqsum / 64'(fold_count - 1'b1)) >> rmv_pkg::VarShift;
      if (vq > VAR_MAX) vq = VAR_MAX;
    end
    r.mean     = fold_mean[31:8];
    r.variance = vq[rmv_pkg::VarW-1:0];
    r.count    = fold_count;
    return r;
  endfunction

  task automatic queue_beat(logic [rmv_pkg::SampleW-1:0] smp, logic clr, logic drn);
    sample_beat_t b;
    b.sample = smp;
    b.clear  = clr;
    b.drain  = drn;
    pending_q.push_back(b);
  endtask

  // driver
  int unsigned tx_gap;
  int unsigned tx_calm;

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    sample_beat_t                nb;
    logic                        nv;
    logic [rmv_pkg::SampleW-1:0] ns;
    logic                        nc;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      clear_i    <= 1'b0;
      tx_gap     = 0;
      tx_calm    = 0;
    end else begin
      nv = in_valid_i;
      ns = sample_i;
      nc = clear_i;
      if (in_valid_i && !in_stall_o) begin
        stats_q.push_back(welford_fold(sample_i, clear_i));
        n_sent++;
        if (clear_i) n_clears++;
        nv = 1'b0;
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          tx_gap = idle_len();
          if ($urandom_range(0, 9) == 0) tx_calm = $urandom_range(8, 40);
        end
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && stats_q.size() != 0)) begin
          nb = pending_q.pop_front();
          nv = 1'b1;
          ns = nb.sample;
          nc = nb.clear;
        end
      end
      in_valid_i <= nv;
      sample_i   <= ns;
      clear_i    <= nc;
    end
  end

  // receiver stall, with two long hold-offs so the core backs up its input
  int unsigned rx_stall_left;
  int unsigned rx_calm;
  int unsigned hold_left;

  always @(posedge clk_i or negedge rst_ni) begin : stall_proc
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      rx_stall_left = 0;
      rx_calm       = 0;
      hold_left     = 0;
    end else begin
      if (hold_left == 0 && n_holds < 2 && n_results >= hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_at   = hold_at + 370;
        n_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ((out_valid_o && !out_stall_i) || $urandom_range(0, 15) == 0) begin
          if (rx_calm > 0) begin
            rx_calm--;
          end else begin
            rx_stall_left = idle_len();
            if ($urandom_range(0, 9) == 0) rx_calm = $urandom_range(8, 40);
          end
        end
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin : check_proc
    stats_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (stats_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("[%0t] unexpected result: mean %h var %h count %0d",
                   $realtime, mean_value_o, variance_value_o, sample_count_o);
      end else begin
        exp_beat = stats_q.pop_front();
        if (mean_value_o !== exp_beat.mean || variance_value_o !== exp_beat.variance ||
            sample_count_o !== exp_beat.count) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"[%0t] result %0d mismatch: exp mean %h var %h count %0d,",
                      " got mean %h var %h count %0d"},
                     $realtime, n_results, exp_beat.mean, exp_beat.variance, exp_beat.count,
                     mean_value_o, variance_value_o, sample_count_o);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("[%0t] timeout: no beat for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, stats_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned                 n_rand;
    int unsigned                 run_len;
    int unsigned                 seq_idx;
    sample_mode_e                mode;
    logic [rmv_pkg::SampleW-1:0] base;
    logic [rmv_pkg::SampleW-1:0] smp;
    fold_count = '0;
    fold_mean  = '0;
    fold_sqsum = '0;
    peak_sqsum = '0;

    // directed: extremes, clears, first sample, equal samples
    queue_beat(16'h0000, 1'b0, 1'b0);
    queue_beat(16'hFFFF, 1'b0, 1'b0);
    queue_beat(16'h0000, 1'b0, 1'b0);
    queue_beat(16'hFFFF, 1'b0, 1'b0);
    queue_beat(16'hFFFF, 1'b0, 1'b0);
    queue_beat(16'hFFFF, 1'b1, 1'b0);  // clear ignores the sample
    queue_beat(16'h0000, 1'b1, 1'b0);  // clear on an already clear state
    queue_beat(16'h3039, 1'b0, 1'b0);
    queue_beat(16'hAAAA, 1'b1, 1'b0);  // clear right after a single sample
    queue_beat(16'h5555, 1'b0, 1'b0);
    queue_beat(16'hAAAA, 1'b0, 1'b0);
    queue_beat(16'h0001, 1'b0, 1'b0);
    queue_beat(16'h8000, 1'b0, 1'b0);
    queue_beat(16'h7FFF, 1'b0, 1'b0);
    queue_beat(16'hFFFE, 1'b0, 1'b0);
    queue_beat(16'h03E8, 1'b1, 1'b1);  // sender pauses for a full drain first
    queue_beat(16'h03E8, 1'b0, 1'b0);
    queue_beat(16'h03E8, 1'b0, 1'b0);
    queue_beat(16'h03E8, 1'b0, 1'b0);
    queue_beat(16'h0000, 1'b1, 1'b0);

    // random: runs of samples closed by a clear, some long enough to saturate
    n_rand  = 0;
    seq_idx = 0;
    while (n_rand < RAND_ITEMS) begin
      if (seq_idx == 0 || seq_idx == 9 || $urandom_range(0, 9) == 0)
        run_len = $urandom_range(WINDOW + 1, WINDOW + 80);
      else
        run_len = $urandom_range(1, 30);
      mode = sample_mode_e'($urandom_range(0, 3));
      base = 16'($urandom);
      for (int unsigned i = 0; i < run_len && n_rand < RAND_ITEMS; i++) begin
        case (mode)
          MODE_RANDOM:  smp = 16'($urandom);
          MODE_EXTREME: smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          MODE_CLUSTER: smp = base + 16'($urandom_range(0, 63)) - 16'd32;
          default:      smp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : base;
        endcase
        // a stray clear now and then breaks a run early
        queue_beat(smp, $urandom_range(0, 99) == 0, 1'b0);
        n_rand++;
      end
      queue_beat(16'($urandom), 1'b1, seq_idx == 1 || $urandom_range(0, 4) == 0);
      n_rand++;
      seq_idx++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i || stats_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d beats in (%0d clears), %0d results checked, %0d mismatches",
             n_sent, n_clears, n_results, n_errors);
    $display("count held at WINDOW on %0d beats, peak sum of squares %h, %0d long hold-offs",
             n_saturated, peak_sqsum, n_holds);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rmv_pkg.sv
sv/running_mean_variance_core.sv
tb/tb.sv
